@@ design/tsfm_pkg.sv @@
// Shared types, widths and pipeline stage map of the touch sample filter.
`timescale 1ns / 1ps
package tsfm_pkg;

   localparam int ADC_BITS         = 12;
   localparam int SAMPLES_PER_AXIS = 5;
   localparam int REG_W            = 12;

   // trimmed mean: drop min and max, divide the rest by a reciprocal multiply
   localparam int TRIM_CNT = SAMPLES_PER_AXIS - 2;
   localparam int SUM_W    = ADC_BITS + $clog2(SAMPLES_PER_AXIS);
   localparam int RECIP_SH = SUM_W + $clog2(TRIM_CNT);
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) + TRIM_CNT - 1) / TRIM_CNT);
   localparam int PROD_W   = SUM_W + RECIP_W;

   localparam int VAL_W      = (ADC_BITS > REG_W) ? ADC_BITS : REG_W;
   localparam int NUM_W      = VAL_W + REG_W;
   localparam int DIV_STAGES = REG_W;

   // stage map
   localparam int ST_MINMAX  = 0;
   localparam int ST_TRIM    = 1;
   localparam int ST_MEAN    = 2;
   localparam int ST_CLAMP   = 3;
   localparam int ST_PROD    = 4;
   localparam int ST_DIV0    = 5;
   localparam int ST_OUT     = ST_DIV0 + DIV_STAGES;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam int CSR_ADDR_W = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CAL_X_MIN     = 3'd0,
      REG_CAL_X_MAX     = 3'd1,
      REG_CAL_Y_MIN     = 3'd2,
      REG_CAL_Y_MAX     = 3'd3,
      REG_SCREEN_WIDTH  = 3'd4,
      REG_SCREEN_HEIGHT = 3'd5
   } csr_index_type;

   typedef logic [ADC_BITS-1:0] sample_type;
   typedef logic [SAMPLES_PER_AXIS-1:0][ADC_BITS-1:0] sample_array_type;
   typedef logic [REG_W-1:0] reg_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef struct packed {
      reg_type lo;
      reg_type hi;
      reg_type size;
   } axis_cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic    in_win;
      reg_type quot;
   } lane_res_type;

endpackage

@@ design/touch_sample_filter_and_map_core.sv @@
// Top level of the resistive touch sample filter and screen mapper.
`timescale 1ns / 1ps
//
// Usage:
//  - req_ channel: one item = pen_down plus five raw samples per axis.
//    An item is taken at a clock edge with req_valid high and req_stall low.
//  - rsp_ channel: one item per request: pressed, screen_x, screen_y.
//    Taken at an edge with rsp_valid high and rsp_stall low.
//  - csr_ port: write csr_wdata to register csr_addr when csr_we is high.
//    Indexes above screen_height are dropped. Write only while idle.
//  - Throughput: one item per cycle while the receiver does not stall; the
//    pipeline depth is set mostly by the 12-stage pipelined divider
//    (one quotient bit per stage) that scales each axis.
//  - Two lanes (X and Y) run side by side; a merge stage combines them.
//  - Stall: each stage moves when the one after it is empty or moving, so
//    bubbles close up behind a stalled result; req_stall rises only when
//    every stage holds an item and the receiver stalls.
//  - Reset (synchronous): pipeline emptied, calibration back to defaults
//    (window 200..3900 on both axes, 240 x 320 screen).
module touch_sample_filter_and_map_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pen_down,
   input  tsfm_pkg::sample_type req_x_sample_0,
   input  tsfm_pkg::sample_type req_x_sample_1,
   input  tsfm_pkg::sample_type req_x_sample_2,
   input  tsfm_pkg::sample_type req_x_sample_3,
   input  tsfm_pkg::sample_type req_x_sample_4,
   input  tsfm_pkg::sample_type req_y_sample_0,
   input  tsfm_pkg::sample_type req_y_sample_1,
   input  tsfm_pkg::sample_type req_y_sample_2,
   input  tsfm_pkg::sample_type req_y_sample_3,
   input  tsfm_pkg::sample_type req_y_sample_4,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pressed,
   output tsfm_pkg::reg_type    rsp_screen_x,
   output tsfm_pkg::reg_type    rsp_screen_y,
   input  logic                 csr_we,
   input  logic [tsfm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  tsfm_pkg::reg_type    csr_wdata
);
   import tsfm_pkg::*;

   localparam reg_type CAL_MIN_RST = 12'd200;
   localparam reg_type CAL_MAX_RST = 12'd3900;
   localparam reg_type WIDTH_RST   = 12'd240;
   localparam reg_type HEIGHT_RST  = 12'd320;

   // calibration registers
   reg_type x_min_ff, x_max_ff, y_min_ff, y_max_ff, scr_w_ff, scr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= CAL_MIN_RST;
         x_max_ff <= CAL_MAX_RST;
         y_min_ff <= CAL_MIN_RST;
         y_max_ff <= CAL_MAX_RST;
         scr_w_ff <= WIDTH_RST;
         scr_h_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CAL_X_MIN:     x_min_ff <= csr_wdata;
            REG_CAL_X_MAX:     x_max_ff <= csr_wdata;
            REG_CAL_Y_MIN:     y_min_ff <= csr_wdata;
            REG_CAL_Y_MAX:     y_max_ff <= csr_wdata;
            REG_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
            REG_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage occupancy and move chain
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] move;
   pipe_ctl_type          ctl;

   always_comb begin
      move[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (move[0]) valid_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (move[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign ctl.load  = move;
   assign req_stall = !move[0];
   assign rsp_valid = valid_ff[ST_OUT];

   // pen level rides alongside the lanes
   logic pen_ff [ST_OUT];

   always_ff @(posedge clock) begin
      if (move[0]) pen_ff[0] <= req_pen_down;
      for (int k = 1; k < ST_OUT; k++) begin
         if (move[k]) pen_ff[k] <= pen_ff[k-1];
      end
   end

   sample_array_type x_samples, y_samples;
   axis_cfg_type     x_cfg, y_cfg;
   lane_res_type     x_res, y_res;

   assign x_samples = {req_x_sample_4, req_x_sample_3, req_x_sample_2,
                       req_x_sample_1, req_x_sample_0};
   assign y_samples = {req_y_sample_4, req_y_sample_3, req_y_sample_2,
                       req_y_sample_1, req_y_sample_0};

   // raw X drives screen_y (height), raw Y drives screen_x (width)
   assign x_cfg = '{lo: x_min_ff, hi: x_max_ff, size: scr_h_ff};
   assign y_cfg = '{lo: y_min_ff, hi: y_max_ff, size: scr_w_ff};

   tsfm_lane u_lane_x (
      .clock   (clock),
      .ctl     (ctl),
      .cfg     (x_cfg),
      .samples (x_samples),
      .res     (x_res)
   );

   tsfm_lane u_lane_y (
      .clock   (clock),
      .ctl     (ctl),
      .cfg     (y_cfg),
      .samples (y_samples),
      .res     (y_res)
   );

   tsfm_merge u_merge (
      .clock         (clock),
      .ctl           (ctl),
      .pen           (pen_ff[ST_OUT-1]),
      .res_x         (x_res),
      .res_y         (y_res),
      .screen_width  (scr_w_ff),
      .screen_height (scr_h_ff),
      .pressed       (rsp_pressed),
      .screen_x      (rsp_screen_x),
      .screen_y      (rsp_screen_y)
   );

   // input side backs up only when the whole pipe is full and held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("req_stall without a full, stalled pipeline");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pressed) |-> (rsp_screen_x == '0 && rsp_screen_y == '0))
      else $error("nonzero coordinates without a touch");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressed && scr_w_ff != '0 && scr_h_ff != '0) |->
      (rsp_screen_x < scr_w_ff && rsp_screen_y < scr_h_ff))
      else $error("coordinate beyond screen size");

endmodule

@@ design/tsfm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tsfm_div (
   input  logic                    clock,
   input  tsfm_pkg::pipe_ctl_type  ctl,
   input  logic [tsfm_pkg::NUM_W-1:0] num,
   input  tsfm_pkg::val_type       dvs,
   input  logic                    tag,
   output tsfm_pkg::lane_res_type  res
);
   import tsfm_pkg::*;

   logic [NUM_W-1:0] rem_ff  [DIV_STAGES];
   reg_type          quot_ff [DIV_STAGES];
   val_type          dvs_ff  [DIV_STAGES];
   logic             tag_ff  [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int BIT = DIV_STAGES - 1 - j;
      logic [NUM_W-1:0] rem_prev;
      logic [NUM_W-1:0] trial;
      logic [NUM_W-1:0] rem_in;
      reg_type          quot_prev;
      reg_type          quot_in;
      val_type          dvs_prev;
      logic             tag_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = num;
         assign quot_prev = '0;
         assign dvs_prev  = dvs;
         assign tag_prev  = tag;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign quot_prev = quot_ff[j-1];
         assign dvs_prev  = dvs_ff[j-1];
         assign tag_prev  = tag_ff[j-1];
      end

      assign trial = NUM_W'(dvs_prev) << BIT;

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            quot_in = quot_prev | (REG_W'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            quot_in = quot_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.load[ST_DIV0 + j]) begin
            rem_ff[j]  <= rem_in;
            quot_ff[j] <= quot_in;
            dvs_ff[j]  <= dvs_prev;
            tag_ff[j]  <= tag_prev;
         end
      end
   end

   assign res.in_win = tag_ff[DIV_STAGES-1];
   assign res.quot   = quot_ff[DIV_STAGES-1];

endmodule

@@ design/tsfm_lane.sv @@
// One axis lane: trimmed mean, window test, clamp and scale to screen size.
`timescale 1ns / 1ps
module tsfm_lane (
   input  logic                       clock,
   input  tsfm_pkg::pipe_ctl_type     ctl,
   input  tsfm_pkg::axis_cfg_type     cfg,
   input  tsfm_pkg::sample_array_type samples,
   output tsfm_pkg::lane_res_type     res
);
   import tsfm_pkg::*;

   sample_type       min_ff, min_in, max_ff, max_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] tsum_ff, tsum_in;
   logic [PROD_W-1:0] prod;
   sample_type       mean_ff, mean_in;
   val_type          raw, lo, hi;
   val_type          clamp_ff, clamp_in;
   logic             win3_ff, win3_in, win4_ff;
   logic [NUM_W-1:0] num_ff, num_in;
   val_type          dvs_ff, dvs_in;

   assign lo = VAL_W'(cfg.lo);
   assign hi = VAL_W'(cfg.hi);

   // sorted-middle sum equals total minus min and max
   always_comb begin
      min_in = samples[0];
      max_in = samples[0];
      sum_in = SUM_W'(samples[0]);
      for (int i = 1; i < SAMPLES_PER_AXIS; i++) begin
         if (samples[i] < min_in) min_in = samples[i];
         if (samples[i] > max_in) max_in = samples[i];
         sum_in = sum_in + SUM_W'(samples[i]);
      end
   end

   assign tsum_in = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
   assign prod    = PROD_W'(tsum_ff) * PROD_W'(RECIP);
   assign mean_in = prod[RECIP_SH +: ADC_BITS];

   assign raw     = VAL_W'(mean_ff);
   assign win3_in = (raw >= lo) && (raw <= hi);

   // raise to min, then lower to max
   always_comb begin
      clamp_in = (raw <= lo) ? lo : raw;
      clamp_in = (clamp_in >= hi) ? hi : clamp_in;
   end

   // empty or inverted window maps to zero: 0 / 1
   always_comb begin
      if ((hi <= lo) || (clamp_ff < lo)) begin
         num_in = '0;
         dvs_in = VAL_W'(1);
      end else begin
         num_in = NUM_W'(clamp_ff - lo) * NUM_W'(cfg.size);
         dvs_in = hi - lo;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_MINMAX]) begin
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
      end
      if (ctl.load[ST_TRIM]) tsum_ff <= tsum_in;
      if (ctl.load[ST_MEAN]) mean_ff <= mean_in;
      if (ctl.load[ST_CLAMP]) begin
         clamp_ff <= clamp_in;
         win3_ff  <= win3_in;
      end
      if (ctl.load[ST_PROD]) begin
         num_ff  <= num_in;
         dvs_ff  <= dvs_in;
         win4_ff <= win3_ff;
      end
   end

   tsfm_div u_div (
      .clock (clock),
      .ctl   (ctl),
      .num   (num_ff),
      .dvs   (dvs_ff),
      .tag   (win4_ff),
      .res   (res)
   );

endmodule

@@ design/tsfm_merge.sv @@
// Merge of the two lanes: touch decision, mirror, cap and output register.
`timescale 1ns / 1ps
module tsfm_merge (
   input  logic                   clock,
   input  tsfm_pkg::pipe_ctl_type ctl,
   input  logic                   pen,
   input  tsfm_pkg::lane_res_type res_x,
   input  tsfm_pkg::lane_res_type res_y,
   input  tsfm_pkg::reg_type      screen_width,
   input  tsfm_pkg::reg_type      screen_height,
   output logic                   pressed,
   output tsfm_pkg::reg_type      screen_x,
   output tsfm_pkg::reg_type      screen_y
);
   import tsfm_pkg::*;

   function automatic reg_type cap(input reg_type v, input reg_type size);
      reg_type r;
      if (size == '0)     r = '0;
      else if (v >= size) r = size - REG_W'(1);
      else                r = v;
      return r;
   endfunction

   logic    pressed_ff, pressed_in;
   reg_type x_ff, x_in, y_ff, y_in;
   reg_type mirror;

   assign mirror     = (res_y.quot <= screen_width) ? screen_width - res_y.quot : '0;
   assign pressed_in = pen || (res_x.in_win && res_y.in_win);
   assign x_in       = pressed_in ? cap(mirror, screen_width) : '0;
   assign y_in       = pressed_in ? cap(res_x.quot, screen_height) : '0;

   always_ff @(posedge clock) begin
      if (ctl.load[ST_OUT]) begin
         pressed_ff <= pressed_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
      end
   end

   assign pressed  = pressed_ff;
   assign screen_x = x_ff;
   assign screen_y = y_ff;

endmodule
